// File: rtl/urs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ultrasonic range sequencer package
// Shared widths, constants, configuration and result types.
// ----------------------------------------------------------------------------
package urs_pkg;

  localparam int CountW = 16;
  localparam int DistW  = 11;

  localparam logic [CountW-1:0] MinIntervalReset  = 16'd40000;
  localparam logic [CountW-1:0] EchoTimeoutReset  = 16'd30000;

  localparam logic [CountW-1:0] TrigLowTicks  = 16'd2;
  localparam logic [CountW-1:0] TrigHighTicks = 16'd10;

  // floor(x / 58) == (x * Div58Mul) >> Div58Shift, exact for all 16-bit x
  localparam int               Div58Shift = 22;
  localparam logic [16:0]      Div58Mul   = 17'd72316;

  // register indexes of the configuration port
  localparam logic CfgMinInterval = 1'b0;
  localparam logic CfgEchoTimeout = 1'b1;

  typedef struct packed {
    logic [CountW-1:0] min_interval_ticks;
    logic [CountW-1:0] echo_timeout_ticks;
  } cfg_t;

  typedef struct packed {
    logic             trigger_level;
    logic [DistW-1:0] distance_cm;
    logic             fresh;
    logic             busy_res;
  } res_t;

  function automatic logic [CountW-1:0] sat_inc(input logic [CountW-1:0] v);
    sat_inc = (&v) ? v : v + 16'd1;
  endfunction

endpackage

// File: rtl/urs_sample_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sample channel
// One tick word: request bit and sampled echo level.
// ----------------------------------------------------------------------------
interface urs_sample_if;
  logic valid;
  logic ready;
  logic request;
  logic echo_level;

  modport source (output valid, output request, output echo_level, input ready);
  modport sink   (input valid, input request, input echo_level, output ready);
endinterface

// File: rtl/urs_result_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Result channel
// One result word per tick: trigger level, held distance, fresh, busy.
// ----------------------------------------------------------------------------
interface urs_result_if;
  logic                       valid;
  logic                       ready;
  logic                       trigger_level;
  logic [urs_pkg::DistW-1:0]  distance_cm;
  logic                       fresh;
  logic                       busy_res;

  modport source (output valid, output trigger_level, output distance_cm,
                  output fresh, output busy_res, input ready);
  modport sink   (input valid, input trigger_level, input distance_cm,
                  input fresh, input busy_res, output ready);
endinterface

// File: rtl/ultrasonic_range_sequencer_top.sv
`timescale 1ns / 1ps
// An accepted tick word is held in the input register, and its result word in the output register.
// Throughput: one tick word per cycle while the result side does not stall.
// Reset (rst, synchronous, active high): idle phase, counters and held distance
// zero, interval 40000 and timeout 30000, both word registers empty.
// ----------------------------------------------------------------------------
// Ultrasonic range sequencer top level
// Drives trigger pulses and times echo pulses, one tick per sample word.
// ----------------------------------------------------------------------------
module ultrasonic_range_sequencer_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wen,
  input  logic                        cfg_idx,
  input  logic [urs_pkg::CountW-1:0]  cfg_data,
  urs_sample_if.sink                  sample,
  urs_result_if.source                result
);

  urs_pkg::cfg_t cfg;
  urs_pkg::res_t core_res;
  urs_pkg::res_t out_word;

  // input register
  logic in_valid;
  logic in_request;
  logic in_echo;

  // output register
  logic out_valid;
  logic advance;

  // Advance the core whenever a word is held and the output register is free
  // or being emptied this cycle.
  assign advance      = in_valid && (!out_valid || result.ready);
  assign sample.ready = !in_valid || advance;

  urs_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .cfg_wen  (cfg_wen),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data),
    .cfg      (cfg)
  );

  urs_core u_core (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .request    (in_request),
    .echo_level (in_echo),
    .cfg        (cfg),
    .res        (core_res)
  );

  // Capture the tick word; hold it while the result side stalls.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (sample.valid && sample.ready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (sample.valid && sample.ready) begin
      in_request <= sample.request;
      in_echo    <= sample.echo_level;
    end
  end

  // Result word register: load on advance, drop once taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) out_word <= core_res;
  end

  assign result.valid         = out_valid;
  assign result.trigger_level = out_word.trigger_level;
  assign result.distance_cm   = out_word.distance_cm;
  assign result.fresh         = out_word.fresh;
  assign result.busy_res      = out_word.busy_res;

endmodule

// File: rtl/urs_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Configuration registers
// Write-only register file for interval and echo timeout.
// ----------------------------------------------------------------------------
module urs_cfg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_wen,
  input  logic                        cfg_idx,
  input  logic [urs_pkg::CountW-1:0]  cfg_data,
  output urs_pkg::cfg_t               cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_interval_ticks <= urs_pkg::MinIntervalReset;
      cfg.echo_timeout_ticks <= urs_pkg::EchoTimeoutReset;
    end else if (cfg_wen) begin
      case (cfg_idx)
        urs_pkg::CfgMinInterval: cfg.min_interval_ticks <= cfg_data;
        urs_pkg::CfgEchoTimeout: cfg.echo_timeout_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/urs_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Ranging sequencer core
// Per-tick phase sequencing, echo timing and distance scaling.
// ----------------------------------------------------------------------------
module urs_core (
  input  logic           clk,
  input  logic           rst,
  input  logic           advance,
  input  logic           request,
  input  logic           echo_level,
  input  urs_pkg::cfg_t  cfg,
  output urs_pkg::res_t  res
);

  localparam logic [2:0] PhIdle     = 3'd0;
  localparam logic [2:0] PhTrigLow  = 3'd1;
  localparam logic [2:0] PhTrigHigh = 3'd2;
  localparam logic [2:0] PhWaitLow  = 3'd3;
  localparam logic [2:0] PhWaitHigh = 3'd4;
  localparam logic [2:0] PhMeasure  = 3'd5;

  logic [2:0]                 phase, phase_next;
  logic [urs_pkg::CountW-1:0] phase_count, phase_count_next;
  logic [urs_pkg::CountW-1:0] timeout_count, timeout_count_next;
  logic [urs_pkg::CountW-1:0] since_start, since_start_next;
  logic [urs_pkg::DistW-1:0]  held_distance, held_distance_next;
  logic [urs_pkg::CountW-1:0] timeout_inc;
  logic [32:0]                scaled;
  logic                       waiting;
  logic                       done;
  logic                       trig;
  logic                       fresh;

  assign scaled      = phase_count * urs_pkg::Div58Mul;
  assign timeout_inc = urs_pkg::sat_inc(timeout_count);

  always_comb begin
    phase_next         = phase;
    phase_count_next   = phase_count;
    timeout_count_next = timeout_count;
    since_start_next   = urs_pkg::sat_inc(since_start);
    held_distance_next = held_distance;
    waiting            = 1'b0;
    done               = 1'b0;
    trig               = 1'b0;
    fresh              = 1'b0;

    case (phase)
      PhIdle: begin
        if (request && since_start >= cfg.min_interval_ticks) begin
          since_start_next = '0;
          phase_next       = PhTrigLow;
          phase_count_next = 16'd1;
        end
      end
      PhTrigLow: begin
        phase_count_next = urs_pkg::sat_inc(phase_count);
        if (phase_count_next >= urs_pkg::TrigLowTicks) begin
          phase_next       = PhTrigHigh;
          phase_count_next = '0;
        end
      end
      PhTrigHigh: begin
        trig             = 1'b1;
        phase_count_next = urs_pkg::sat_inc(phase_count);
        if (phase_count_next >= urs_pkg::TrigHighTicks) begin
          phase_next         = PhWaitLow;
          phase_count_next   = '0;
          timeout_count_next = '0;
        end
      end
      PhWaitLow: begin
        waiting = 1'b1;
        if (!echo_level) phase_next = PhWaitHigh;
      end
      PhWaitHigh: begin
        waiting = 1'b1;
        if (echo_level) begin
          phase_next       = PhMeasure;
          phase_count_next = 16'd1;
        end
      end
      PhMeasure: begin
        waiting = 1'b1;
        if (echo_level) begin
          phase_count_next = urs_pkg::sat_inc(phase_count);
        end else begin
          held_distance_next = scaled[urs_pkg::Div58Shift +: urs_pkg::DistW];
          fresh              = 1'b1;
          done               = 1'b1;
        end
      end
      default: phase_next = PhIdle;
    endcase

    if (waiting) begin
      timeout_count_next = timeout_inc;
      // a pulse that ends on the timeout tick still wins
      if (!done && timeout_inc >= cfg.echo_timeout_ticks) begin
        held_distance_next = '0;
        fresh              = 1'b1;
        done               = 1'b1;
      end
      if (done) begin
        phase_next         = PhIdle;
        phase_count_next   = '0;
        timeout_count_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PhIdle;
      phase_count   <= '0;
      timeout_count <= '0;
      since_start   <= '0;
      held_distance <= '0;
    end else if (advance) begin
      phase         <= phase_next;
      phase_count   <= phase_count_next;
      timeout_count <= timeout_count_next;
      since_start   <= since_start_next;
      held_distance <= held_distance_next;
    end
  end

  assign res.trigger_level = trig;
  assign res.distance_cm   = held_distance_next;
  assign res.fresh         = fresh;
  assign res.busy_res      = (phase_next != PhIdle);

endmodule
